FILE: src/tbo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tbo_pkg;

  localparam int unsigned NumStg   = 7;
  localparam int unsigned ApbAddrW = 2;
  localparam int unsigned VoxW     = 13;
  localparam logic [ApbAddrW-1:0] RegVoxelSize = 2'd0;
  localparam logic [VoxW-1:0]     VoxelSizeRst = 13'd256;

  typedef struct packed {
    logic [NumStg-1:0] adv;
  } tbo_ctl_t;

  // true when the interval spanned by p0..p2 lies outside [-r, r]
  function automatic logic sep3(input logic signed [53:0] p0, input logic signed [53:0] p1,
                                input logic signed [53:0] p2, input logic signed [53:0] r);
    logic signed [53:0] lo;
    logic signed [53:0] hi;
    lo = p0;
    hi = p0;
    if (p1 < lo) lo = p1;
    if (p1 > hi) hi = p1;
    if (p2 < lo) lo = p2;
    if (p2 > hi) hi = p2;
    return (lo > r) || (hi < -r);
  endfunction

endpackage
`default_nettype wire

FILE: src/tbo_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tbo_in_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] a_x;
  logic signed [23:0] a_y;
  logic signed [23:0] a_z;
  logic signed [23:0] b_x;
  logic signed [23:0] b_y;
  logic signed [23:0] b_z;
  logic signed [23:0] c_x;
  logic signed [23:0] c_y;
  logic signed [23:0] c_z;
  logic [9:0]        cell_x;
  logic [9:0]        cell_y;
  logic [9:0]        cell_z;
  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 cell_x, cell_y, cell_z, input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
               cell_x, cell_y, cell_z, output ready);
endinterface

interface tbo_out_if;
  logic valid;
  logic ready;
  logic overlap;
  modport source(output valid, overlap, input ready);
  modport sink(input valid, overlap, output ready);
endinterface
`default_nettype wire

FILE: src/triangle_box_overlap_test.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Protocol          Payload
// in_i       in   valid/ready       a_*, b_*, c_* (s24 Q15.8), cell_x/y/z (u10)
// out_o      out  valid/ready       overlap (1 bit)
// apb        in   APB write/read    voxel_size at byte address 0 (13 bits)
//
// One item per cycle while the output is not stalled; a result passes through
// the seven register stages (offset, box axes, products, edge axes, plane
// partial products, plane sums, compare) before it is valid at out_o.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stalled output holds without losing items.
// rst_ni clears the stage valid bits and sets voxel_size to 256.
module triangle_box_overlap_test #(
  parameter int unsigned GRID_DIM = 1024
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  tbo_in_if.sink                            in_i,
  tbo_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tbo_pkg::ApbAddrW-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [12:0]                    vs_q;
  logic [tbo_pkg::NumStg-1:0]     vld_q;
  logic [tbo_pkg::NumStg-1:0]     vld_d;
  tbo_pkg::tbo_ctl_t              ctl;
  logic signed [23:0]             vtx [3][3];
  logic [9:0]                     cell_idx [3];
  logic signed [25:0]             fv [3][3];
  logic signed [26:0]             fe [3][3];
  logic                           f_ok;
  logic signed [54:0]             an [3];
  logic signed [25:0]             av0 [3];
  logic                           a_ok;
  logic                           ovl;

  assign pready = 1'b1;
  assign prdata = (paddr == tbo_pkg::RegVoxelSize) ? {19'b0, vs_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= tbo_pkg::VoxelSizeRst;
    end else if (psel && penable && pwrite && paddr == tbo_pkg::RegVoxelSize) begin
      vs_q <= pwdata[12:0];
    end
  end

  always_comb begin
    ctl.adv[tbo_pkg::NumStg-1] = !vld_q[tbo_pkg::NumStg-1] || out_o.ready;
    for (int k = tbo_pkg::NumStg - 2; k >= 0; k--) begin
      ctl.adv[k] = !vld_q[k] || ctl.adv[k+1];
    end
    vld_d[0] = ctl.adv[0] ? in_i.valid : vld_q[0];
    for (int k = 1; k < tbo_pkg::NumStg; k++) begin
      vld_d[k] = ctl.adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready    = ctl.adv[0];
  assign out_o.valid   = vld_q[tbo_pkg::NumStg-1];
  assign out_o.overlap = ovl;

  assign vtx[0][0] = in_i.a_x;
  assign vtx[0][1] = in_i.a_y;
  assign vtx[0][2] = in_i.a_z;
  assign vtx[1][0] = in_i.b_x;
  assign vtx[1][1] = in_i.b_y;
  assign vtx[1][2] = in_i.b_z;
  assign vtx[2][0] = in_i.c_x;
  assign vtx[2][1] = in_i.c_y;
  assign vtx[2][2] = in_i.c_z;
  assign cell_idx[0] = in_i.cell_x;
  assign cell_idx[1] = in_i.cell_y;
  assign cell_idx[2] = in_i.cell_z;

  tbo_front #(
    .GRID_DIM(GRID_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .voxel_size_i(vs_q),
    .vtx_i       (vtx),
    .cell_i      (cell_idx),
    .v_o         (fv),
    .e_o         (fe),
    .ok_o        (f_ok)
  );

  tbo_axes u_axes (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .voxel_size_i(vs_q),
    .v_i         (fv),
    .e_i         (fe),
    .ok_i        (f_ok),
    .n_o         (an),
    .v0_o        (av0),
    .ok_o        (a_ok)
  );

  tbo_plane u_plane (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .voxel_size_i(vs_q),
    .n_i         (an),
    .v0_i        (av0),
    .ok_i        (a_ok),
    .overlap_o   (ovl)
  );

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (vld_q[tbo_pkg::NumStg-1] && !out_o.ready) |=> vld_q[tbo_pkg::NumStg-1])
    else $error("output stage lost a stalled result");
  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (vld_q[tbo_pkg::NumStg-2] && ctl.adv[tbo_pkg::NumStg-1])
      |=> vld_q[tbo_pkg::NumStg-1])
    else $error("item dropped entering the output stage");
  a_rdy_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !vld_q[0] |-> in_i.ready)
    else $error("ready low with an empty first stage");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (psel && penable && pwrite && paddr == tbo_pkg::RegVoxelSize)
      |=> vs_q == $past(pwdata[12:0]))
    else $error("voxel_size write not taken");
`endif

endmodule
`default_nettype wire

FILE: src/tbo_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tbo_front #(
  parameter int unsigned GRID_DIM = 1024
) (
  input  wire                  clk_i,
  input  tbo_pkg::tbo_ctl_t    ctl_i,
  input  logic [12:0]          voxel_size_i,
  input  logic signed [23:0]   vtx_i [3][3],
  input  logic [9:0]           cell_i [3],
  output logic signed [25:0]   v_o [3][3],
  output logic signed [26:0]   e_o [3][3],
  output logic                 ok_o
);

  localparam logic [12:0] GridLim = 13'(GRID_DIM);

  logic [23:0]        ctr [3];
  logic [2:0]         cell_ok;
  logic signed [25:0] v0_d [3][3];
  logic signed [25:0] v0_q [3][3];
  logic               ok0_q;
  logic [2:0]         box_sep;
  logic signed [26:0] e1_d [3][3];
  logic signed [25:0] v1_q [3][3];
  logic signed [26:0] e1_q [3][3];
  logic               ok1_q;
  logic signed [53:0] half;

  assign half = $signed({41'b0, voxel_size_i});

  for (genvar k = 0; k < 3; k++) begin : g_ax
    assign ctr[k]     = 24'({cell_i[k], 1'b1}) * 24'(voxel_size_i);
    assign cell_ok[k] = {3'b000, cell_i[k]} < GridLim;
    for (genvar i = 0; i < 3; i++) begin : g_vt
      // doubled coordinates, centered on the voxel
      assign v0_d[i][k] = 26'($signed({vtx_i[i][k], 1'b0})) - $signed({2'b00, ctr[k]});
    end
    assign box_sep[k] = tbo_pkg::sep3(54'(v0_q[0][k]), 54'(v0_q[1][k]), 54'(v0_q[2][k]),
                                      half);
    assign e1_d[0][k] = 27'(v0_q[1][k]) - 27'(v0_q[0][k]);
    assign e1_d[1][k] = 27'(v0_q[2][k]) - 27'(v0_q[1][k]);
    assign e1_d[2][k] = 27'(v0_q[0][k]) - 27'(v0_q[2][k]);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[0]) begin
      v0_q  <= v0_d;
      ok0_q <= &cell_ok;
    end
    if (ctl_i.adv[1]) begin
      v1_q  <= v0_q;
      e1_q  <= e1_d;
      ok1_q <= ok0_q && !(|box_sep);
    end
  end

  assign v_o  = v1_q;
  assign e_o  = e1_q;
  assign ok_o = ok1_q;

endmodule
`default_nettype wire

FILE: src/tbo_axes.sv
`timescale 1ns / 1ps
`default_nettype none
module tbo_axes (
  input  wire                  clk_i,
  input  tbo_pkg::tbo_ctl_t    ctl_i,
  input  logic [12:0]          voxel_size_i,
  input  logic signed [25:0]   v_i [3][3],
  input  logic signed [26:0]   e_i [3][3],
  input  logic                 ok_i,
  output logic signed [54:0]   n_o [3],
  output logic signed [25:0]   v0_o [3],
  output logic                 ok_o
);

  logic signed [53:0] nm_d [6];
  logic signed [53:0] nm_q [6];
  logic [26:0]        mag [3][3];
  logic signed [52:0] pm_d [9][3][2];
  logic signed [52:0] pm_q [9][3][2];
  logic [40:0]        rad_d [9];
  logic [40:0]        rad_q [9];
  logic signed [25:0] v2_q [3];
  logic               ok2_q;
  logic signed [54:0] n_d [3];
  logic [8:0]         ax_sep;
  logic signed [54:0] n3_q [3];
  logic signed [25:0] v3_q [3];
  logic               ok3_q;

  // normal component products
  assign nm_d[0] = e_i[0][1] * e_i[1][2];
  assign nm_d[1] = e_i[0][2] * e_i[1][1];
  assign nm_d[2] = e_i[0][2] * e_i[1][0];
  assign nm_d[3] = e_i[0][0] * e_i[1][2];
  assign nm_d[4] = e_i[0][0] * e_i[1][1];
  assign nm_d[5] = e_i[0][1] * e_i[1][0];

  for (genvar i = 0; i < 3; i++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_mag
      assign mag[i][k] = e_i[i][k][26] ? 27'(-e_i[i][k]) : 27'(e_i[i][k]);
    end
    for (genvar a = 0; a < 3; a++) begin : g_axis
      localparam int U = (a + 1) % 3;
      localparam int W = (a + 2) % 3;
      for (genvar j = 0; j < 3; j++) begin : g_vtx
        assign pm_d[i*3+a][j][0] = e_i[i][W] * v_i[j][U];
        assign pm_d[i*3+a][j][1] = e_i[i][U] * v_i[j][W];
      end
      assign rad_d[i*3+a] = 41'(voxel_size_i) * 41'(28'(mag[i][U]) + 28'(mag[i][W]));
      assign ax_sep[i*3+a] = tbo_pkg::sep3(
          54'(pm_q[i*3+a][0][0]) - 54'(pm_q[i*3+a][0][1]),
          54'(pm_q[i*3+a][1][0]) - 54'(pm_q[i*3+a][1][1]),
          54'(pm_q[i*3+a][2][0]) - 54'(pm_q[i*3+a][2][1]),
          $signed({13'b0, rad_q[i*3+a]}));
    end
  end

  assign n_d[0] = 55'(nm_q[0]) - 55'(nm_q[1]);
  assign n_d[1] = 55'(nm_q[2]) - 55'(nm_q[3]);
  assign n_d[2] = 55'(nm_q[4]) - 55'(nm_q[5]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[2]) begin
      nm_q    <= nm_d;
      pm_q    <= pm_d;
      rad_q   <= rad_d;
      v2_q[0] <= v_i[0][0];
      v2_q[1] <= v_i[0][1];
      v2_q[2] <= v_i[0][2];
      ok2_q   <= ok_i;
    end
    if (ctl_i.adv[3]) begin
      n3_q  <= n_d;
      v3_q  <= v2_q;
      ok3_q <= ok2_q && !(|ax_sep);
    end
  end

  assign n_o  = n3_q;
  assign v0_o = v3_q;
  assign ok_o = ok3_q;

endmodule
`default_nettype wire

FILE: src/tbo_plane.sv
`timescale 1ns / 1ps
`default_nettype none
module tbo_plane (
  input  wire                  clk_i,
  input  tbo_pkg::tbo_ctl_t    ctl_i,
  input  logic [12:0]          voxel_size_i,
  input  logic signed [54:0]   n_i [3],
  input  logic signed [25:0]   v0_i [3],
  input  logic                 ok_i,
  output logic                 overlap_o
);

  logic signed [54:0] pl_d [3];
  logic signed [52:0] ph_d [3];
  logic [54:0]        nmag [3];
  logic signed [54:0] pl_q [3];
  logic signed [52:0] ph_q [3];
  logic [56:0]        msum_q;
  logic               ok4_q;
  logic signed [54:0] dh_q;
  logic signed [56:0] dl_q;
  logic [41:0]        rlo_q;
  logic [40:0]        rhi_q;
  logic               ok5_q;
  logic signed [85:0] d;
  logic signed [85:0] r;
  logic               ovl_q;

  // split the normal so each partial product stays narrow
  for (genvar k = 0; k < 3; k++) begin : g_ax
    assign pl_d[k] = $signed({1'b0, n_i[k][27:0]}) * v0_i[k];
    assign ph_d[k] = $signed(n_i[k][54:28]) * v0_i[k];
    assign nmag[k] = n_i[k][54] ? 55'(-n_i[k]) : 55'(n_i[k]);
  end

  assign d = (86'(dh_q) <<< 28) + 86'(dl_q);
  assign r = $signed({16'b0, rhi_q, 29'b0}) + $signed({44'b0, rlo_q});

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[4]) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      msum_q <= 57'(nmag[0]) + 57'(nmag[1]) + 57'(nmag[2]);
      ok4_q  <= ok_i;
    end
    if (ctl_i.adv[5]) begin
      dh_q  <= 55'(ph_q[0]) + 55'(ph_q[1]) + 55'(ph_q[2]);
      dl_q  <= 57'(pl_q[0]) + 57'(pl_q[1]) + 57'(pl_q[2]);
      rlo_q <= 42'(voxel_size_i) * 42'(msum_q[28:0]);
      rhi_q <= 41'(voxel_size_i) * 41'(msum_q[56:29]);
      ok5_q <= ok4_q;
    end
    if (ctl_i.adv[6]) begin
      ovl_q <= ok5_q && !((d > r) || (d < -r));
    end
  end

  assign overlap_o = ovl_q;

endmodule
`default_nettype wire
